// ===== src/pma_pkg.sv =====
// shared constants, types and helper functions for the particle moment accumulator
`default_nettype none
package pma_pkg;

	localparam int AXES       = 3;
	localparam int IN_DATA_W  = 224;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 360;
	localparam int CFG_DATA_W = 32;

	localparam logic [2:0] MODE_GAS      = 3'd0;
	localparam logic [2:0] MODE_DARK     = 3'd1;
	localparam logic [2:0] MODE_STAR     = 3'd2;
	localparam logic [2:0] MODE_GAS_STAR = 3'd3;
	localparam logic [2:0] MODE_ALL      = 3'd4;

	localparam logic [1:0] KIND_GAS  = 2'd0;
	localparam logic [1:0] KIND_DARK = 2'd1;
	localparam logic [1:0] KIND_STAR = 2'd2;

	localparam logic REG_CLASS_MODE = 1'b0;
	localparam logic REG_BOX_VOLUME = 1'b1;

	typedef logic signed [31:0] q824_t;
	typedef logic signed [63:0] acc_t;

	function automatic logic kind_selected(logic [2:0] mode, logic [1:0] kind);
		logic sel;
		case (mode)
			MODE_GAS:      sel = (kind == KIND_GAS);
			MODE_DARK:     sel = (kind == KIND_DARK);
			MODE_STAR:     sel = (kind == KIND_STAR);
			MODE_GAS_STAR: sel = (kind == KIND_GAS) || (kind == KIND_STAR);
			MODE_ALL:      sel = (kind == KIND_GAS) || (kind == KIND_DARK) ||
			                     (kind == KIND_STAR);
			default:       sel = 1'b0;
		endcase
		return sel;
	endfunction

	function automatic logic [1:0] axis_next(logic [1:0] a);
		logic [1:0] r;
		case (a)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] axis_prev(logic [1:0] a);
		logic [1:0] r;
		case (a)
			2'd0:    r = 2'd2;
			2'd1:    r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

	// saturating signed 64-bit add
	function automatic acc_t sat_add64(acc_t a, acc_t b);
		logic signed [64:0] s;
		acc_t r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else
			r = s[63:0];
		return r;
	endfunction

	function automatic q824_t sat32_66(logic signed [65:0] v);
		q824_t r;
		if (!v[65] && (v[64:31] != 34'd0))
			r = 32'sh7FFFFFFF;
		else if (v[65] && (v[64:31] != {34{1'b1}}))
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/particle_moment_accumulator.sv =====
// particle moment accumulator: mass, center of mass, drift and specific angular momentum
// a counted particle goes through transfer, 15 products on one shared multiplier, drain and check
// an uncounted particle that is not last leaves the block idle and ready for the next one
// a last particle with mass adds ten divisions on one shared divider (each after its own load
// state), 6 cross products, a drain and an output state; the result waits in an output
// register; asynchronous active-low reset clears sums, class_mode all, box_volume 1.0
`default_nettype none
module particle_moment_accumulator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic                           cfg_index,
	input  wire logic [pma_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// particle_mass, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
	input  wire logic [pma_pkg::IN_DATA_W-1:0]  s_tdata,
	// particle_kind, is_marked
	input  wire logic [pma_pkg::IN_USER_W-1:0]  s_tuser,
	input  wire logic                           s_tlast,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// total_mass, density, center_x/y/z, drift_x/y/z, spin_x/y/z, zero pad
	output logic [pma_pkg::OUT_DATA_W-1:0]      m_tdata,
	// status
	output logic                                m_tuser
);
	import pma_pkg::*;

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_ACC     = 4'd1;
	localparam logic [3:0] ST_WAIT_A  = 4'd2;
	localparam logic [3:0] ST_CHECK   = 4'd3;
	localparam logic [3:0] ST_DIV_LD  = 4'd4;
	localparam logic [3:0] ST_DIV_RUN = 4'd5;
	localparam logic [3:0] ST_CRS     = 4'd6;
	localparam logic [3:0] ST_WAIT_C  = 4'd7;
	localparam logic [3:0] ST_OUT     = 4'd8;

	logic [3:0]  state_q;
	logic [2:0]  class_mode_q;
	logic [31:0] box_volume_q;

	logic [31:0] mass_q;
	q824_t       pos_q [AXES];
	q824_t       vel_q [AXES];
	logic        last_q;

	logic [63:0] mass_sum_q;
	acc_t        pos_acc_q [AXES];
	acc_t        vel_acc_q [AXES];
	acc_t        spin_acc_q [AXES];

	logic [1:0]  axis_q;
	logic [2:0]  sub_q;
	logic        act_q;
	logic        act_crs_q;
	logic [1:0]  act_axis_q;
	logic [2:0]  act_sub_q;

	logic signed [33:0] op_a;
	logic signed [33:0] op_b;
	logic signed [67:0] prod_q;
	acc_t               t_q;
	logic signed [32:0] rvh_q;
	logic signed [64:0] diff;

	logic [3:0]  d_q;
	logic [6:0]  k_q;
	logic [63:0] num_q;
	logic [63:0] r_q;
	logic [63:0] quo_q;
	logic        ovf_q;
	logic        neg_q;

	logic        status_q;
	logic [32:0] total_q;
	logic [31:0] density_q;
	q824_t       com_q [AXES];
	q824_t       drift_q [AXES];
	acc_t        l_q [AXES];
	q824_t       spin_q [AXES];

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  m_tuser_q;

	logic        accept;
	logic        counted;
	logic [64:0] mass_add;
	logic [1:0]  aj;
	logic [1:0]  ak;

	logic [63:0] den;
	logic [63:0] cap;
	logic [6:0]  k_last;
	acc_t        div_src;
	logic        bit_in;
	logic [64:0] r_sh;
	logic        ge;
	logic [63:0] r_nx;
	logic [63:0] q_nx;
	logic        ovf_nx;
	logic [63:0] q_fin;
	logic [63:0] q_sgn;
	q824_t       q_32;
	logic        div_done;

	logic signed [40:0] cc_fl;
	logic signed [65:0] spin_v;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign counted  = s_tuser[2] && kind_selected(class_mode_q, s_tuser[1:0]);
	assign mass_add = {1'b0, mass_sum_q} + {33'd0, s_tdata[31:0]};
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	assign aj = axis_next(axis_q);
	assign ak = axis_prev(axis_q);

	// shared multiplier operands
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_CRS) begin
			if (!sub_q[0]) begin
				op_a = {{2{com_q[aj][31]}}, com_q[aj]};
				op_b = {{2{drift_q[ak][31]}}, drift_q[ak]};
			end else begin
				op_a = {{2{com_q[ak][31]}}, com_q[ak]};
				op_b = {{2{drift_q[aj][31]}}, drift_q[aj]};
			end
		end else begin
			case (sub_q)
				3'd0: begin
					op_a = {{2{pos_q[aj][31]}}, pos_q[aj]};
					op_b = {{2{vel_q[ak][31]}}, vel_q[ak]};
				end
				3'd1: begin
					op_a = {{2{pos_q[ak][31]}}, pos_q[ak]};
					op_b = {{2{vel_q[aj][31]}}, vel_q[aj]};
				end
				3'd2: begin
					op_a = {2'b00, mass_q};
					op_b = {{2{pos_q[axis_q][31]}}, pos_q[axis_q]};
				end
				3'd3: begin
					op_a = {2'b00, mass_q};
					op_b = {rvh_q[32], rvh_q};
				end
				default: begin
					op_a = {2'b00, mass_q};
					op_b = {{2{vel_q[axis_q][31]}}, vel_q[axis_q]};
				end
			endcase
		end
	end

	assign diff   = {t_q[63], t_q} - {prod_q[63], prod_q[63:0]};
	assign cc_fl  = diff[64:24];
	assign spin_v = {{2{l_q[act_axis_q][63]}}, l_q[act_axis_q]} - {{25{cc_fl[40]}}, cc_fl};

	// divider operand selection
	always_comb begin
		den    = mass_sum_q;
		cap    = 64'h0000_0000_8000_0000;
		k_last = 7'd87;
		case (d_q)
			4'd0: begin
				den    = {32'd0, box_volume_q};
				cap    = 64'h0000_0000_FFFF_FFFF;
				k_last = 7'd79;
			end
			4'd7, 4'd8, 4'd9: cap = 64'h4000_0000_0000_0000;
			default: cap = 64'h0000_0000_8000_0000;
		endcase
	end

	always_comb begin
		case (d_q)
			4'd1:    div_src = pos_acc_q[0];
			4'd2:    div_src = pos_acc_q[1];
			4'd3:    div_src = pos_acc_q[2];
			4'd4:    div_src = vel_acc_q[0];
			4'd5:    div_src = vel_acc_q[1];
			4'd6:    div_src = vel_acc_q[2];
			4'd7:    div_src = spin_acc_q[0];
			4'd8:    div_src = spin_acc_q[1];
			4'd9:    div_src = spin_acc_q[2];
			default: div_src = mass_sum_q;
		endcase
	end

	assign bit_in   = num_q[63];
	assign r_sh     = {r_q, bit_in};
	assign ge       = r_sh[64] || (r_sh[63:0] >= den);
	assign r_nx     = ge ? (r_sh[63:0] - den) : r_sh[63:0];
	assign q_nx     = {quo_q[62:0], ge};
	assign ovf_nx   = ovf_q || (q_nx > cap);
	assign q_fin    = ovf_nx ? cap : q_nx;
	assign q_sgn    = neg_q ? (64'd0 - q_fin) : q_fin;
	assign q_32     = (!neg_q && q_fin[31]) ? 32'sh7FFFFFFF : q_sgn[31:0];
	assign div_done = (state_q == ST_DIV_RUN) && (k_q == k_last);

	// control, configuration and sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			class_mode_q <= MODE_ALL;
			box_volume_q <= 32'd16777216;
			mass_sum_q   <= '0;
			for (int i = 0; i < AXES; i++) begin
				pos_acc_q[i]  <= '0;
				vel_acc_q[i]  <= '0;
				spin_acc_q[i] <= '0;
			end
			axis_q     <= '0;
			sub_q      <= '0;
			act_q      <= 1'b0;
			act_crs_q  <= 1'b0;
			act_axis_q <= '0;
			act_sub_q  <= '0;
			d_q        <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_CLASS_MODE)
					class_mode_q <= cfg_data[2:0];
				else
					box_volume_q <= cfg_data;
			end
			if ((state_q == ST_OUT) && (!m_tvalid_q || m_tready))
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			act_q      <= (state_q == ST_ACC) || (state_q == ST_CRS);
			act_crs_q  <= (state_q == ST_CRS);
			act_axis_q <= axis_q;
			act_sub_q  <= sub_q;

			if (act_q && !act_crs_q) begin
				case (act_sub_q)
					3'd2: pos_acc_q[act_axis_q] <= sat_add64(pos_acc_q[act_axis_q],
						{{20{prod_q[67]}}, prod_q[67:24]});
					3'd3: spin_acc_q[act_axis_q] <= sat_add64(spin_acc_q[act_axis_q],
						{{12{prod_q[67]}}, prod_q[67:16]});
					3'd4: vel_acc_q[act_axis_q] <= sat_add64(vel_acc_q[act_axis_q],
						{{20{prod_q[67]}}, prod_q[67:24]});
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (counted) begin
							mass_sum_q <= mass_add[64] ? {64{1'b1}} : mass_add[63:0];
							state_q    <= ST_ACC;
						end else if (s_tlast) begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_ACC: begin
					if (sub_q == 3'd4) begin
						sub_q <= '0;
						if (axis_q == 2'd2) begin
							axis_q  <= '0;
							state_q <= ST_WAIT_A;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						sub_q <= sub_q + 3'd1;
					end
				end
				ST_WAIT_A: state_q <= ST_CHECK;
				ST_CHECK: begin
					d_q <= '0;
					if (!last_q)
						state_q <= ST_IDLE;
					else if (mass_sum_q == 64'd0)
						state_q <= ST_OUT;
					else
						state_q <= ST_DIV_LD;
				end
				ST_DIV_LD: begin
					k_q     <= '0;
					state_q <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					k_q <= k_q + 7'd1;
					if (div_done) begin
						if (d_q == 4'd9) begin
							axis_q  <= '0;
							sub_q   <= '0;
							state_q <= ST_CRS;
						end else begin
							d_q     <= d_q + 4'd1;
							state_q <= ST_DIV_LD;
						end
					end
				end
				ST_CRS: begin
					if (sub_q[0]) begin
						sub_q <= '0;
						if (axis_q == 2'd2) begin
							axis_q  <= '0;
							state_q <= ST_WAIT_C;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						sub_q <= 3'd1;
					end
				end
				ST_WAIT_C: state_q <= ST_OUT;
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						mass_sum_q <= '0;
						for (int i = 0; i < AXES; i++) begin
							pos_acc_q[i]  <= '0;
							vel_acc_q[i]  <= '0;
							spin_acc_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;

		if (accept) begin
			mass_q   <= s_tdata[31:0];
			pos_q[0] <= s_tdata[63:32];
			pos_q[1] <= s_tdata[95:64];
			pos_q[2] <= s_tdata[127:96];
			vel_q[0] <= s_tdata[159:128];
			vel_q[1] <= s_tdata[191:160];
			vel_q[2] <= s_tdata[223:192];
			last_q   <= s_tlast;
		end

		if (act_q) begin
			if (act_sub_q == 3'd0)
				t_q <= prod_q[63:0];
			else if (!act_crs_q && (act_sub_q == 3'd1))
				rvh_q <= diff[64:32];
			if (act_crs_q && (act_sub_q == 3'd1))
				spin_q[act_axis_q] <= sat32_66(spin_v);
		end

		if (state_q == ST_CHECK) begin
			status_q  <= (mass_sum_q == 64'd0);
			total_q   <= (mass_sum_q[63:33] != 31'd0) ? {33{1'b1}} : mass_sum_q[32:0];
			density_q <= '0;
			for (int i = 0; i < AXES; i++) begin
				com_q[i]   <= '0;
				drift_q[i] <= '0;
				spin_q[i]  <= '0;
			end
		end

		if (state_q == ST_DIV_LD) begin
			neg_q <= (d_q != 4'd0) && div_src[63];
			num_q <= ((d_q != 4'd0) && div_src[63]) ? (64'd0 - div_src) : div_src;
			r_q   <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (state_q == ST_DIV_RUN) begin
			num_q <= {num_q[62:0], 1'b0};
			r_q   <= r_nx;
			quo_q <= q_nx;
			ovf_q <= ovf_nx;
			if (div_done) begin
				case (d_q)
					4'd0:    density_q  <= q_fin[31:0];
					4'd1:    com_q[0]   <= q_32;
					4'd2:    com_q[1]   <= q_32;
					4'd3:    com_q[2]   <= q_32;
					4'd4:    drift_q[0] <= q_32;
					4'd5:    drift_q[1] <= q_32;
					4'd6:    drift_q[2] <= q_32;
					4'd7:    l_q[0]     <= q_sgn;
					4'd8:    l_q[1]     <= q_sgn;
					4'd9:    l_q[2]     <= q_sgn;
					default: ;
				endcase
			end
		end

		if ((state_q == ST_OUT) && (!m_tvalid_q || m_tready)) begin
			m_tuser_q <= status_q;
			m_tdata_q <= {7'd0, spin_q[2], spin_q[1], spin_q[0],
				drift_q[2], drift_q[1], drift_q[0],
				com_q[2], com_q[1], com_q[0], density_q, total_q};
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench for the particle moment accumulator: directed and random particle sets checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import pma_pkg::*;

	typedef struct {
		logic [1:0]   kind;
		logic         marked;
		logic [31:0]  mass;
		logic [31:0]  pos [3];
		logic [31:0]  vel [3];
		logic         last;
	} particle_t;

	typedef struct {
		logic         status;
		logic [32:0]  total_mass;
		logic [31:0]  density;
		logic [31:0]  center [3];
		logic [31:0]  drift [3];
		logic [31:0]  spin [3];
	} moments_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_CLASS_MODE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic [IN_USER_W-1:0] s_tuser = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;

	particle_moment_accumulator uut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [2:0]         mode_q = MODE_ALL;
	logic [31:0]        volume_q = 32'd16777216;
	logic [63:0]        mass_acc;
	logic signed [63:0] pos_acc [3];
	logic signed [63:0] vel_acc [3];
	logic signed [63:0] spin_acc [3];

	particle_t pending_particles [$];
	moments_t  expected_moments [$];
	int errors = 0;
	int results_seen = 0;
	int sets_sent = 0;
	longint cycles = 0;

	function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat_q824(logic signed [127:0] x);
		if (x > 128'sd2147483647)
			return 64'sd2147483647;
		if (x < -128'sd2147483648)
			return -64'sd2147483648;
		return x[63:0];
	endfunction

	// x * 2^24 / den truncated toward zero, magnitude capped
	function automatic logic signed [127:0] scaled_quot(logic signed [63:0] x,
			logic [63:0] den, logic [127:0] cap);
		logic [127:0] mag;
		logic [127:0] q;
		mag = x < 0 ? 128'(-$signed({x[63], x})) : 128'(x);
		q = (mag << 24) / den;
		if (q > cap)
			q = cap;
		return x < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic logic same_moments(moments_t a, moments_t b);
		logic ok;
		ok = (a.status === b.status) && (a.total_mass === b.total_mass) &&
		     (a.density === b.density);
		for (int i = 0; i < 3; i++)
			ok = ok && (a.center[i] === b.center[i]) && (a.drift[i] === b.drift[i]) &&
			     (a.spin[i] === b.spin[i]);
		return ok;
	endfunction

	function automatic void clear_moments();
		mass_acc = '0;
		for (int i = 0; i < 3; i++) begin
			pos_acc[i] = '0;
			vel_acc[i] = '0;
			spin_acc[i] = '0;
		end
	endfunction

	function automatic logic counts(logic [1:0] k);
		case (mode_q)
			MODE_GAS:      return k == KIND_GAS;
			MODE_DARK:     return k == KIND_DARK;
			MODE_STAR:     return k == KIND_STAR;
			MODE_GAS_STAR: return k == KIND_GAS || k == KIND_STAR;
			MODE_ALL:      return k == KIND_GAS || k == KIND_DARK || k == KIND_STAR;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic void accumulate_particle(particle_t p);
		logic signed [63:0] m, r [3], v [3], rv [3];
		logic [64:0] ms;
		moments_t e;
		logic signed [63:0] c [3], d [3];
		logic signed [127:0] cc, l, den;
		logic signed [63:0] s64;
		if (p.marked && counts(p.kind)) begin
			m = {32'd0, p.mass};
			for (int i = 0; i < 3; i++) begin
				r[i] = $signed(p.pos[i]);
				v[i] = $signed(p.vel[i]);
			end
			for (int i = 0; i < 3; i++)
				rv[i] = r[(i+1)%3] * v[(i+2)%3] - r[(i+2)%3] * v[(i+1)%3];
			ms = {1'b0, mass_acc} + {33'd0, p.mass};
			mass_acc = ms[64] ? '1 : ms[63:0];
			for (int i = 0; i < 3; i++) begin
				pos_acc[i] = sadd(pos_acc[i], (m * r[i]) >>> 24);
				vel_acc[i] = sadd(vel_acc[i], (m * v[i]) >>> 24);
				spin_acc[i] = sadd(spin_acc[i], (m * (rv[i] >>> 32)) >>> 16);
			end
		end
		if (!p.last)
			return;
		e.status = 1'b0;
		e.total_mass = '0;
		e.density = '0;
		for (int i = 0; i < 3; i++) begin
			e.center[i] = '0;
			e.drift[i] = '0;
			e.spin[i] = '0;
		end
		if (mass_acc == 0) begin
			e.status = 1'b1;
		end else begin
			e.total_mass = mass_acc > 64'h1FFFFFFFF ? '1 : mass_acc[32:0];
			if (volume_q == 0)
				e.density = '1;
			else begin
				den = ({64'd0, mass_acc} << 16) / volume_q;
				e.density = den > 128'hFFFFFFFF ? '1 : den[31:0];
			end
			for (int i = 0; i < 3; i++) begin
				c[i] = sat_q824(scaled_quot(pos_acc[i], mass_acc, 128'h80000000));
				d[i] = sat_q824(scaled_quot(vel_acc[i], mass_acc, 128'h80000000));
				e.center[i] = c[i][31:0];
				e.drift[i] = d[i][31:0];
			end
			for (int i = 0; i < 3; i++) begin
				cc = c[(i+1)%3] * d[(i+2)%3] - c[(i+2)%3] * d[(i+1)%3];
				l = scaled_quot(spin_acc[i], mass_acc, 128'h4000000000000000);
				l = 128'(sadd(l[63:0], 64'(-(cc >>> 24))));
				s64 = sat_q824(l);
				e.spin[i] = s64[31:0];
			end
		end
		expected_moments.push_back(e);
		clear_moments();
	endfunction

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return $urandom_range(0, 1) ? 32'($urandom_range(0, 255)) :
			          -32'($urandom_range(0, 255));
			default: return $urandom;
		endcase
	endfunction

	function automatic particle_t rnd_particle(logic last);
		particle_t p;
		p.kind = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
		p.marked = $urandom_range(0, 5) != 0;
		case ($urandom_range(0, 5))
			0: p.mass = '1;
			1: p.mass = '0;
			2: p.mass = $urandom_range(1, 1000);
			default: p.mass = $urandom;
		endcase
		for (int i = 0; i < 3; i++) begin
			p.pos[i] = rnd_coord();
			p.vel[i] = rnd_coord();
		end
		p.last = last;
		return p;
	endfunction

	// driver
	particle_t cur;
	int send_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_tvalid && s_tready) begin
			accumulate_particle(cur);
			void'(pending_particles.pop_front());
		end
		if ((s_tvalid && s_tready) || !s_tvalid) begin
			if (send_gap > 0 || pending_particles.size() == 0) begin
				s_tvalid <= 1'b0;
				if (send_gap > 0)
					send_gap <= send_gap - 1;
			end else begin
				particle_t nx;
				nx = pending_particles[0];
				cur <= nx;
				s_tvalid <= 1'b1;
				s_tdata <= {nx.vel[2], nx.vel[1], nx.vel[0], nx.pos[2], nx.pos[1],
				            nx.pos[0], nx.mass};
				s_tuser <= {nx.marked, nx.kind};
				s_tlast <= nx.last;
				send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			end
		end
	end

	// monitor
	int recv_gap = 0;
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			moments_t e, a;
			a.status = m_tuser;
			a.total_mass = m_tdata[32:0];
			a.density = m_tdata[64:33];
			for (int i = 0; i < 3; i++) begin
				a.center[i] = m_tdata[65 + 32*i +: 32];
				a.drift[i] = m_tdata[161 + 32*i +: 32];
				a.spin[i] = m_tdata[257 + 32*i +: 32];
			end
			results_seen++;
			if (expected_moments.size() == 0) begin
				$display("%0t: unexpected result status=%0d", $time, a.status);
				errors++;
			end else begin
				e = expected_moments.pop_front();
				if (!same_moments(a, e)) begin
					$display("%0t: mismatch exp st=%0d m=%h d=%h c=%h %h %h v=%h %h %h s=%h %h %h",
					         $time, e.status, e.total_mass, e.density, e.center[0],
					         e.center[1], e.center[2], e.drift[0], e.drift[1], e.drift[2],
					         e.spin[0], e.spin[1], e.spin[2]);
					$display("%0t:          got st=%0d m=%h d=%h c=%h %h %h v=%h %h %h s=%h %h %h",
					         $time, a.status, a.total_mass, a.density, a.center[0],
					         a.center[1], a.center[2], a.drift[0], a.drift[1], a.drift[2],
					         a.spin[0], a.spin[1], a.spin[2]);
					errors++;
				end
			end
			recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
			m_tready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (cycles > 64'd4000000) begin
			$display("timeout");
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic drain();
		while (pending_particles.size() != 0 || s_tvalid || expected_moments.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CLASS_MODE)
			mode_q = val[2:0];
		else
			volume_q = val;
	endtask

	task automatic add_set(int n);
		for (int i = 0; i < n; i++)
			pending_particles.push_back(rnd_particle(i == n - 1));
		sets_sent++;
	endtask

	initial begin
		particle_t p;
		int total;
		clear_moments();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: extremes, unmarked set, zero mass, kind 3, single particle
		p = rnd_particle(1'b0);
		p.kind = KIND_GAS; p.marked = 1'b1; p.mass = '1;
		for (int i = 0; i < 3; i++) begin p.pos[i] = 32'h7FFFFFFF; p.vel[i] = 32'h80000000; end
		pending_particles.push_back(p);
		p.kind = KIND_STAR; p.pos[1] = 32'h80000000; p.vel[2] = 32'h7FFFFFFF; p.last = 1'b1;
		pending_particles.push_back(p);
		p.marked = 1'b0; pending_particles.push_back(p);
		p.marked = 1'b1; p.mass = '0; pending_particles.push_back(p);
		p.mass = 32'd5; p.kind = 2'd3; pending_particles.push_back(p);
		p.kind = KIND_DARK; pending_particles.push_back(p);
		for (int i = 0; i < 4; i++) begin
			p = rnd_particle(i == 3); p.marked = 1'b1; p.mass = '1; p.kind = KIND_DARK;
			pending_particles.push_back(p);
		end
		drain();
		write_reg(REG_BOX_VOLUME, 32'd0);
		add_set(3);
		drain();
		write_reg(REG_BOX_VOLUME, 32'd1);
		add_set(2);
		drain();
		write_reg(REG_BOX_VOLUME, 32'hFFFFFFFF);
		add_set(2);
		drain();

		// random phases across modes and volumes
		total = 0;
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_CLASS_MODE, ph < 8 ? 32'(ph) : 32'($urandom_range(0, 4)));
			write_reg(REG_BOX_VOLUME, ph == 9 ? 32'd1 : $urandom_range(1, 32'hFFFFFFFF));
			while (total < 75 * (ph + 1)) begin
				int n;
				n = $urandom_range(1, 8);
				add_set(n);
				total += n;
			end
			drain();
		end

		$display("covered %0d particle sets, %0d results across all class modes", sets_sent,
		         results_seen);
		$display("volume extremes zero, one and full scale, saturating masses and coordinates");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
